// ----- rtl/core/bcs_pkg.sv -----
`default_nettype none

package bcs_pkg;

  // stack geometry
  localparam int unsigned STACK_DEPTH = 256;
  localparam int unsigned IDX_W       = $clog2(STACK_DEPTH);
  localparam int unsigned PTR_W       = $clog2(STACK_DEPTH + 1);

  // fixed field widths
  localparam int unsigned ACTION_W = 2;
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned ERROR_W  = 2;

  // action codes
  typedef enum logic [ACTION_W-1:0] {
    ACT_EXPLORE = 2'd0,
    ACT_END_RUN = 2'd1,
    ACT_RESET   = 2'd2
  } action_e;

  // error codes
  localparam logic [ERROR_W-1:0] ERR_OK       = 2'd0;
  localparam logic [ERROR_W-1:0] ERR_MISMATCH = 2'd1;
  localparam logic [ERROR_W-1:0] ERR_FULL     = 2'd2;

  // one stack entry
  typedef struct packed {
    logic [BYTE_W-1:0] chosen_index;
    logic [BYTE_W-1:0] option_count;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

  // one result transaction
  typedef struct packed {
    logic [BYTE_W-1:0]  choice;
    logic [BYTE_W-1:0]  depth;
    logic               fresh;
    logic               more_runs;
    logic [ERROR_W-1:0] error;
  } result_t;

endpackage

`default_nettype wire

// ----- rtl/core/bcs_ram.sv -----
`default_nettype none

module bcs_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 256,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port, holds its data between reads
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/bcs_ctrl.sv -----
`default_nettype none

module bcs_ctrl (
  input  wire logic                                   clk_i,
  input  wire logic                                   rst_ni,
  input  wire logic                                   in_valid_i,
  output logic                                        in_stall_o,
  input  wire logic [bcs_pkg::ACTION_W-1:0]           action_i,
  input  wire logic [bcs_pkg::BYTE_W-1:0]             num_choices_i,
  output logic                                        res_valid_o,
  input  wire logic                                   res_free_i,
  output bcs_pkg::result_t                            res_o,
  output logic                                        ram_re_o,
  output logic [bcs_pkg::IDX_W-1:0]                   ram_raddr_o,
  input  wire bcs_pkg::entry_t                        ram_rdata_i,
  output logic                                        ram_we_o,
  output logic [bcs_pkg::IDX_W-1:0]                   ram_waddr_o,
  output bcs_pkg::entry_t                             ram_wdata_o
);

  localparam int unsigned PTR_W = bcs_pkg::PTR_W;
  localparam int unsigned IDX_W = bcs_pkg::IDX_W;
  localparam int unsigned BW    = bcs_pkg::BYTE_W;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_e;

  state_e                          state_q, state_d;
  logic [PTR_W-1:0]                len_q, len_d;
  logic [PTR_W-1:0]                cursor_q, cursor_d;
  logic [PTR_W-1:0]                open_q, open_d;
  logic [PTR_W-1:0]                pend_q, pend_d;
  logic [bcs_pkg::ACTION_W-1:0]    act_q;
  logic [BW-1:0]                   want_q;

  logic                            accept;
  logic                            complete;
  logic                            stored;
  logic [PTR_W-1:0]                pos_inc;
  logic [IDX_W-1:0]                pos;
  logic [BW-1:0]                   idx;
  logic [BW-1:0]                   cnt;

  // input handshake and memory read of the entry under the cursor
  assign in_stall_o  = (state_q != ST_IDLE);
  assign accept      = in_valid_i && !in_stall_o;
  assign ram_re_o    = accept;
  assign ram_raddr_o = cursor_q[IDX_W-1:0];

  assign complete    = (state_q == ST_EXEC) && res_free_i;
  assign res_valid_o = complete;

  // entry selection: stored entry under the cursor or a new one at the top
  assign stored  = (cursor_q < len_q);
  assign pos     = stored ? cursor_q[IDX_W-1:0] : len_q[IDX_W-1:0];
  assign pos_inc = stored ? cursor_q + PTR_W'(1) : len_q + PTR_W'(1);

  // read, modify and write back
  always_comb begin
    state_d     = state_q;
    len_d       = len_q;
    cursor_d    = cursor_q;
    open_d      = open_q;
    pend_d      = pend_q;
    res_o       = '0;
    ram_we_o    = 1'b0;
    ram_waddr_o = pos;
    idx         = ram_rdata_i.chosen_index;
    cnt         = ram_rdata_i.option_count;
    ram_wdata_o = '{chosen_index: idx, option_count: cnt};

    if (accept) begin
      state_d = ST_EXEC;
    end

    if (complete) begin
      state_d = ST_IDLE;
      unique case (bcs_pkg::action_e'(act_q))
        bcs_pkg::ACT_EXPLORE: begin
          if (stored) begin
            cursor_d = pos_inc;
            if (cnt != want_q) begin
              res_o.error = bcs_pkg::ERR_MISMATCH;
            end
            if (pend_q == pos_inc) begin
              idx         = idx + BW'(1);
              ram_we_o    = 1'b1;
              ram_wdata_o = '{chosen_index: idx, option_count: cnt};
              len_d       = pos_inc;
              pend_d      = '0;
            end
          end else if (len_q == PTR_W'(bcs_pkg::STACK_DEPTH)) begin
            res_o.error = bcs_pkg::ERR_FULL;
          end else begin
            idx         = '0;
            cnt         = want_q;
            ram_we_o    = 1'b1;
            ram_wdata_o = '{chosen_index: idx, option_count: cnt};
            len_d       = pos_inc;
            cursor_d    = pos_inc;
            res_o.fresh = 1'b1;
          end
          if (stored || len_q != PTR_W'(bcs_pkg::STACK_DEPTH)) begin
            if (({1'b0, idx} + (BW + 1)'(1)) < {1'b0, cnt}) begin
              open_d = pos_inc;
            end
            res_o.choice = idx;
            res_o.depth  = BW'(pos);
          end
        end
        bcs_pkg::ACT_END_RUN: begin
          pend_d          = open_q;
          open_d          = '0;
          cursor_d        = '0;
          res_o.more_runs = (open_q != '0);
        end
        bcs_pkg::ACT_RESET: begin
          len_d    = '0;
          cursor_d = '0;
          open_d   = '0;
          pend_d   = '0;
        end
        default: begin
        end
      endcase
    end
  end

  // state and pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      len_q    <= '0;
      cursor_q <= '0;
      open_q   <= '0;
      pend_q   <= '0;
    end else begin
      state_q  <= state_d;
      len_q    <= len_d;
      cursor_q <= cursor_d;
      open_q   <= open_d;
      pend_q   <= pend_d;
    end
  end

  // captured transaction fields
  always_ff @(posedge clk_i) begin
    if (accept) begin
      act_q  <= action_i;
      want_q <= num_choices_i;
    end
  end

  // pointer ordering invariants and the stack write condition
  a_len_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_q <= PTR_W'(bcs_pkg::STACK_DEPTH))
    else $error("stack length beyond capacity");

  a_cursor_in_stack: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cursor_q <= len_q)
    else $error("cursor beyond stored end");

  a_open_behind_cursor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    open_q <= cursor_q)
    else $error("open point ahead of cursor");

  a_pend_in_stack: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q <= len_q)
    else $error("pending backtrack beyond stored end");

  a_write_only_on_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we_o |-> (complete && act_q == bcs_pkg::ACT_EXPLORE))
    else $error("stack write outside an explore transaction");

endmodule

`default_nettype wire

// ----- rtl/core/backtracking_choice_stack_core.sv -----
// Choice-point stack for depth-first enumeration of runs.
// Input channel (in_valid_i / in_stall_o) carries action_i and num_choices_i:
// explore asks for the option to take at the next depth, end of run rewinds
// to depth zero and arms the deepest open point as the next backtrack, and
// full reset empties the stack. Output channel (out_valid_o / out_stall_i)
// returns one transaction per input: choice_o, depth_o, fresh_o,
// more_runs_o and error_o.
// In the core, the entry under the cursor is read from the stack memory
// at acceptance, then modified and written back while the pointers update
// once the output register is free. The pointer update of one transaction
// must finish before the next memory read, so a new transaction is taken
// only after the previous one has completed; its result is then written
// into the output register.
// An output register holds a result while the receiver stalls; the core
// still takes the next transaction and holds its own result until the
// register frees.
// Reset clears the stack length and all pointers and empties the output
// register; stack memory contents are not cleared and need no sweep.
`default_nettype none

module backtracking_choice_stack_core (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                in_valid_i,
  output logic                                     in_stall_o,
  input  wire logic [bcs_pkg::ACTION_W-1:0]        action_i,
  input  wire logic [bcs_pkg::BYTE_W-1:0]          num_choices_i,
  output logic                                     out_valid_o,
  input  wire logic                                out_stall_i,
  output logic [bcs_pkg::BYTE_W-1:0]               choice_o,
  output logic [bcs_pkg::BYTE_W-1:0]               depth_o,
  output logic                                     fresh_o,
  output logic                                     more_runs_o,
  output logic [bcs_pkg::ERROR_W-1:0]              error_o
);

  logic                           res_valid;
  logic                           res_free;
  bcs_pkg::result_t               res;
  bcs_pkg::result_t               out_q;
  logic                           out_valid_q;
  logic                           ram_re;
  logic [bcs_pkg::IDX_W-1:0]      ram_raddr;
  logic [bcs_pkg::ENTRY_W-1:0]    ram_rdata;
  logic                           ram_we;
  logic [bcs_pkg::IDX_W-1:0]      ram_waddr;
  bcs_pkg::entry_t                ram_wdata;

  // stack memory
  bcs_ram #(
    .WIDTH (bcs_pkg::ENTRY_W),
    .DEPTH (bcs_pkg::STACK_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // sequencer and pointers
  bcs_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .action_i      (action_i),
    .num_choices_i (num_choices_i),
    .res_valid_o   (res_valid),
    .res_free_i    (res_free),
    .res_o         (res),
    .ram_re_o      (ram_re),
    .ram_raddr_o   (ram_raddr),
    .ram_rdata_i   (bcs_pkg::entry_t'(ram_rdata)),
    .ram_we_o      (ram_we),
    .ram_waddr_o   (ram_waddr),
    .ram_wdata_o   (ram_wdata)
  );

  // output register, frees when empty or being taken
  assign res_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_valid) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign choice_o    = out_q.choice;
  assign depth_o     = out_q.depth;
  assign fresh_o     = out_q.fresh;
  assign more_runs_o = out_q.more_runs;
  assign error_o     = out_q.error;

endmodule

`default_nettype wire

// ----- bench/backtracking_choice_stack_core_test.sv -----
`timescale 1ns / 1ps

// tracks the choice stack and checks every result transaction in order
class choice_stack_tracker;
  localparam int unsigned BW    = bcs_pkg::BYTE_W;
  localparam int unsigned PW    = bcs_pkg::PTR_W;
  localparam int unsigned IW    = bcs_pkg::IDX_W;
  localparam int unsigned DEPTH = bcs_pkg::STACK_DEPTH;

  logic [BW-1:0]     chosen_idx [DEPTH];
  logic [BW-1:0]     option_cnt [DEPTH];
  logic [PW-1:0]     stack_len;
  logic [PW-1:0]     cursor;
  logic [PW-1:0]     latest_open;
  logic [PW-1:0]     pending_bt;
  logic              last_more_runs;
  bcs_pkg::result_t  awaited[$];
  int unsigned       checked;
  int unsigned       failures;

  function new();
    stack_len      = '0;
    cursor         = '0;
    latest_open    = '0;
    pending_bt     = '0;
    last_more_runs = 1'b0;
    checked        = 0;
    failures       = 0;
  endfunction

  // work out the result of one accepted input transaction
  function void note_transaction(logic [bcs_pkg::ACTION_W-1:0] act, logic [BW-1:0] want);
    bcs_pkg::result_t r;
    logic [PW-1:0]    pos;
    logic [IW-1:0]    slot;
    bit               used;
    r    = '0;
    used = 1'b0;
    pos  = '0;
    slot = '0;
    case (act)
      bcs_pkg::ACT_EXPLORE: begin
        if (cursor < stack_len) begin
          // revisit a stored entry, advancing it at the backtrack point
          pos    = cursor;
          slot   = pos[IW-1:0];
          cursor = pos + PW'(1);
          used   = 1'b1;
          if (option_cnt[slot] != want) r.error = bcs_pkg::ERR_MISMATCH;
          if (pending_bt == pos + PW'(1)) begin
            chosen_idx[slot] = chosen_idx[slot] + BW'(1);
            stack_len        = pos + PW'(1);
            pending_bt       = '0;
          end
        end else if (stack_len >= PW'(DEPTH)) begin
          r.error = bcs_pkg::ERR_FULL;
        end else begin
          // push a fresh entry past the end
          pos              = stack_len;
          slot             = pos[IW-1:0];
          chosen_idx[slot] = '0;
          option_cnt[slot] = want;
          stack_len        = pos + PW'(1);
          cursor           = pos + PW'(1);
          r.fresh          = 1'b1;
          used             = 1'b1;
        end
        if (used) begin
          if (({1'b0, chosen_idx[slot]} + (BW + 1)'(1)) < {1'b0, option_cnt[slot]})
            latest_open = pos + PW'(1);
          r.choice = chosen_idx[slot];
          r.depth  = pos[BW-1:0];
        end
      end
      bcs_pkg::ACT_END_RUN: begin
        pending_bt     = latest_open;
        latest_open    = '0;
        cursor         = '0;
        r.more_runs    = (pending_bt != '0);
        last_more_runs = r.more_runs;
      end
      bcs_pkg::ACT_RESET: begin
        stack_len   = '0;
        cursor      = '0;
        latest_open = '0;
        pending_bt  = '0;
      end
      default: ;
    endcase
    awaited.insert(awaited.size(), r);
  endfunction

  function void report_field(string field, logic [BW-1:0] want, logic [BW-1:0] got);
    if (want != got) begin
      failures++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
    end
  endfunction

  // compare one result transaction with the oldest prediction
  function void check_result(bcs_pkg::result_t got);
    bcs_pkg::result_t want;
    if (awaited.size() == 0) begin
      failures++;
      $display("%0t: result with nothing awaited, expected none, got choice %0d depth %0d",
               $time, got.choice, got.depth);
      return;
    end
    want = awaited.pop_front();
    checked++;
    report_field("choice", want.choice, got.choice);
    report_field("depth", want.depth, got.depth);
    report_field("fresh", BW'(want.fresh), BW'(got.fresh));
    report_field("more_runs", BW'(want.more_runs), BW'(got.more_runs));
    report_field("error", BW'(want.error), BW'(got.error));
  endfunction
endclass

module backtracking_choice_stack_core_test;

  localparam int unsigned AW    = bcs_pkg::ACTION_W;
  localparam int unsigned BW    = bcs_pkg::BYTE_W;
  localparam int unsigned EW    = bcs_pkg::ERROR_W;
  localparam int unsigned DEPTH = bcs_pkg::STACK_DEPTH;

  // action code the block ignores
  localparam logic [AW-1:0] ACT_UNUSED = 2'd3;

  logic            clk_i         = 1'b0;
  logic            rst_ni        = 1'b0;
  logic            in_valid_i    = 1'b0;
  logic            in_stall_o;
  logic [AW-1:0]   action_i      = '0;
  logic [BW-1:0]   num_choices_i = '0;
  logic            out_valid_o;
  logic            out_stall_i   = 1'b0;
  logic [BW-1:0]   choice_o;
  logic [BW-1:0]   depth_o;
  logic            fresh_o;
  logic            more_runs_o;
  logic [EW-1:0]   error_o;

  int unsigned send_idle_pct  = 31;
  int unsigned recv_stall_pct = 85;
  int unsigned item_count     = 0;

  choice_stack_tracker tracker = new();

  backtracking_choice_stack_core uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .action_i      (action_i),
    .num_choices_i (num_choices_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .choice_o      (choice_o),
    .depth_o       (depth_o),
    .fresh_o       (fresh_o),
    .more_runs_o   (more_runs_o),
    .error_o       (error_o)
  );

  // clock
  always #10 clk_i = ~clk_i;

  // random receiver stalls
  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(0, 99) < recv_stall_pct);
  end

  // check each accepted result transaction
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      tracker.check_result({choice_o, depth_o, fresh_o, more_runs_o, error_o});
    end
  end

  // present one transaction, with random idle cycles ahead of it
  task automatic send_item(input logic [AW-1:0] act, input logic [BW-1:0] nc);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(0, 99) < send_idle_pct);
    end
    in_valid_i    <= 1'b1;
    action_i      <= act;
    num_choices_i <= nc;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    tracker.note_transaction(act, nc);
    if (act != ACT_UNUSED) item_count++;
  endtask

  // enumerate runs of a fixed choice tree, with some noise and broken runs
  task automatic run_session(input int budget);
    logic [BW-1:0] counts [8];
    int            n_depth;
    int            used;
    int            cut;
    n_depth = int'($urandom_range(1, 6));
    for (int d = 0; d < 8; d++) begin
      if ($urandom_range(0, 9) == 0) counts[d] = BW'($urandom_range(0, 255));
      else counts[d] = BW'($urandom_range(1, 3));
    end
    send_item(bcs_pkg::ACT_RESET, BW'($urandom_range(0, 255)));
    used = 1;
    while (used < budget) begin
      cut = ($urandom_range(0, 19) == 0) ? int'($urandom_range(0, n_depth + 1)) : n_depth;
      for (int d = 0; d < cut; d++) begin
        if ($urandom_range(0, 29) == 0)
          send_item(AW'($urandom_range(0, 3)), BW'($urandom_range(0, 255)));
        else if ($urandom_range(0, 29) == 0)
          send_item(bcs_pkg::ACT_EXPLORE, BW'($urandom_range(0, 255)));
        else
          send_item(bcs_pkg::ACT_EXPLORE, counts[d]);
        used++;
      end
      send_item(bcs_pkg::ACT_END_RUN, BW'($urandom_range(0, 255)));
      used++;
      if (!tracker.last_more_runs) break;
    end
  endtask

  // fill the stack to the top, overflow it, then replay for a deep backtrack
  task automatic fill_and_replay();
    logic [BW-1:0] counts [DEPTH];
    send_item(bcs_pkg::ACT_RESET, BW'($urandom_range(0, 255)));
    for (int d = 0; d < DEPTH; d++) begin
      counts[d] = BW'($urandom_range(0, 4));
      send_item(bcs_pkg::ACT_EXPLORE, counts[d]);
    end
    repeat (3) send_item(bcs_pkg::ACT_EXPLORE, BW'($urandom_range(0, 255)));
    send_item(bcs_pkg::ACT_END_RUN, BW'($urandom_range(0, 255)));
    for (int d = 0; d < DEPTH; d++) send_item(bcs_pkg::ACT_EXPLORE, counts[d]);
    repeat (2) send_item(bcs_pkg::ACT_EXPLORE, BW'($urandom_range(0, 255)));
    send_item(bcs_pkg::ACT_END_RUN, BW'($urandom_range(0, 255)));
  endtask

  task automatic run_phase(input int unsigned target);
    int unsigned start;
    start = item_count;
    while (item_count - start < target) run_session(int'($urandom_range(20, 150)));
  endtask

  // main sequence
  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: extremes, zero options, mismatch, backtrack, reset, unused action
    send_item(bcs_pkg::ACT_EXPLORE, 8'd255);
    send_item(bcs_pkg::ACT_EXPLORE, 8'd1);
    send_item(bcs_pkg::ACT_EXPLORE, 8'd0);
    send_item(ACT_UNUSED, 8'hAA);
    send_item(bcs_pkg::ACT_END_RUN, 8'h00);
    send_item(bcs_pkg::ACT_EXPLORE, 8'd254);
    send_item(bcs_pkg::ACT_EXPLORE, 8'd7);
    send_item(bcs_pkg::ACT_END_RUN, 8'hFF);
    send_item(bcs_pkg::ACT_EXPLORE, 8'd255);
    send_item(bcs_pkg::ACT_RESET, 8'h55);
    send_item(bcs_pkg::ACT_END_RUN, 8'h0F);
    send_item(bcs_pkg::ACT_EXPLORE, 8'd0);
    send_item(bcs_pkg::ACT_END_RUN, 8'hF0);
    send_item(bcs_pkg::ACT_EXPLORE, 8'd128);
    send_item(bcs_pkg::ACT_RESET, 8'hFF);

    // sender idles little, receiver stalls a lot
    run_phase(400);

    // sender idles a lot, receiver stalls little
    send_idle_pct  = 85;
    recv_stall_pct = 31;
    fill_and_replay();
    run_phase(160);

    // no idling on either side
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    run_phase(400);

    // drain
    in_valid_i <= 1'b0;
    while (tracker.awaited.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    $display("covered %0d transactions over three idling phases, incl. stack fill and overflow",
             item_count);
    $display("%0d results checked, %0d mismatches", tracker.checked, tracker.failures);
    if (tracker.failures == 0 && tracker.awaited.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // watchdog
  initial begin
    #20ms;
    $display("timeout with %0d results outstanding", tracker.awaited.size());
    $display("FAILED: results differ");
    $finish;
  end

endmodule
